### design/uabt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uabt_pkg;

	// widths of time, window and levels
	localparam int TIME_BITS  = 48;
	localparam int WIN_BITS   = 32;
	localparam int LEVEL_W    = 3;
	localparam int STREAK_W   = 8;
	localparam int SEC_W      = 16;
	localparam int NUM_LEVELS = 5;
	localparam int MAX_LEVEL  = 5;
	localparam int MS_PER_SEC = 1000;
	localparam int ADD_W      = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// opcodes
	localparam logic [1:0] OP_FAIL    = 2'd0;
	localparam logic [1:0] OP_SUCCESS = 2'd1;
	localparam logic [1:0] OP_DECAY   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_L1         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_L2         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_L3         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_L4         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC_L5         = 3'd6;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [TIME_BITS-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic                 decayed;
		logic [LEVEL_W-1:0]   level_out;
		logic [STREAK_W-1:0]  streak_out;
		logic [TIME_BITS-1:0] lockout_until;
		logic [TIME_BITS-1:0] last_failure_out;
	} out_t;

	// divider request and response
	typedef struct packed {
		logic                 start;
		logic [TIME_BITS-1:0] dividend;
		logic [WIN_BITS-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [TIME_BITS-1:0] quotient;
		logic [WIN_BITS-1:0]  remainder;
	} div_resp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FAIL,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### design/uabt_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module uabt_divider import uabt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_req_t  req,
	output div_resp_t      resp
);

	localparam int CNT_W = $clog2(TIME_BITS);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TIME_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] num_q;
	logic [WIN_BITS-1:0]  rem_q;
	logic [WIN_BITS-1:0]  den_q;
	logic [WIN_BITS:0]    trial;
	logic                 fits;
	logic [WIN_BITS-1:0]  rem_next;

	// one restoring step: shift in the next dividend bit and try to subtract
	always_comb begin
		trial    = {rem_q, num_q[TIME_BITS-1]};
		fits     = trial >= {1'b0, den_q};
		rem_next = fits ? WIN_BITS'(trial - {1'b0, den_q}) : trial[WIN_BITS-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TIME_BITS-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign resp.busy      = busy_q;
	assign resp.done      = done_q;
	assign resp.quotient  = num_q;
	assign resp.remainder = rem_q;

endmodule

`default_nettype wire

### design/unlock_attempt_backoff_throttle_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                          payload
// in        in_valid, in_stall, in_data      opcode, now_ms
// out       out_valid, out_stall, out_data   decayed, level, streak, deadline, last failure
// cfg       cfg_we, cfg_idx, cfg_wdata       seven throttle registers
//
// an item with a decay divide waits in ST_DIV on the divider, and one without skips it;
// the restoring divider (one quotient bit per cycle, 48 steps) runs only for such an item
// in_stall is high from acceptance until the result sits in the output register
// a result waits in the output register while out_stall is high; the next item is taken
// reset clears the record and loads the default register values, no clearing pass

module unlock_attempt_backoff_throttle_core import uabt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [LEVEL_W-1:0]  MAX_LVL = LEVEL_W'(MAX_LEVEL);
	localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	state_t state_q, state_d;

	// configuration
	logic [STREAK_W-1:0] thresh_q;
	logic [WIN_BITS-1:0] window_q;
	logic [SEC_W-1:0]    sec_q [NUM_LEVELS];

	// record
	logic [STREAK_W-1:0]  streak_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [TIME_BITS-1:0] deadline_q;
	logic [TIME_BITS-1:0] last_q;

	// item in flight
	logic [1:0]           op_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 dec_q;
	logic [ADD_W-1:0]     add_q;

	logic                 out_valid_q;
	out_t                 out_q;

	div_req_t             div_req;
	div_resp_t            div_resp;

	logic                 in_acc;
	logic                 out_free;
	logic                 decay_ok;
	logic                 op_decays;
	logic [STREAK_W-1:0]  streak_inc;
	logic [TIME_BITS:0]   sum;

	// level to lockout table slot
	function automatic logic [2:0] sec_slot(input logic [LEVEL_W-1:0] lvl);
		logic [2:0] slot;
		if (lvl <= LEVEL_W'(1))
			slot = 3'd0;
		else if (lvl >= LEVEL_W'(NUM_LEVELS))
			slot = 3'(NUM_LEVELS - 1);
		else
			slot = 3'(lvl - 1'b1);
		return slot;
	endfunction

	uabt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// decay preconditions, saturating streak increment, deadline sum and divider request
	always_comb begin
		op_decays  = (op_q == OP_FAIL) || (op_q == OP_DECAY);
		decay_ok   = op_decays && (level_q != '0) && (last_q != '0) &&
			(now_q > last_q) && (window_q != '0);
		streak_inc = (streak_q == STREAK_MAX) ? streak_q : streak_q + 1'b1;
		sum        = {1'b0, now_q} + (TIME_BITS + 1)'(add_q);
		div_req.start    = (state_q == ST_CHECK) && decay_ok;
		div_req.dividend = now_q - last_q;
		div_req.divisor  = window_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (decay_ok)
					state_d = ST_DIV;
				else if (op_q == OP_FAIL)
					state_d = ST_FAIL;
				else
					state_d = ST_DONE;
			end
			ST_DIV: begin
				if (div_resp.done)
					state_d = (op_q == OP_FAIL) ? ST_FAIL : ST_DONE;
			end
			ST_FAIL: begin
				state_d = (streak_inc >= thresh_q) ? ST_MUL : ST_DONE;
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= STREAK_W'(5);
			window_q <= WIN_BITS'(900000);
			sec_q[0] <= SEC_W'(10);
			sec_q[1] <= SEC_W'(30);
			sec_q[2] <= SEC_W'(60);
			sec_q[3] <= SEC_W'(120);
			sec_q[4] <= SEC_W'(300);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FAIL_THRESHOLD: thresh_q <= cfg_wdata[STREAK_W-1:0];
				CFG_DECAY_WINDOW:   window_q <= cfg_wdata[WIN_BITS-1:0];
				CFG_SEC_L1:         sec_q[0] <= cfg_wdata[SEC_W-1:0];
				CFG_SEC_L2:         sec_q[1] <= cfg_wdata[SEC_W-1:0];
				CFG_SEC_L3:         sec_q[2] <= cfg_wdata[SEC_W-1:0];
				CFG_SEC_L4:         sec_q[3] <= cfg_wdata[SEC_W-1:0];
				CFG_SEC_L5:         sec_q[4] <= cfg_wdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// record updates, one step per state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streak_q   <= '0;
			level_q    <= '0;
			deadline_q <= '0;
			last_q     <= '0;
		end else begin
			case (state_q)
				ST_CHECK: begin
					if (op_q == OP_SUCCESS) begin
						streak_q   <= '0;
						level_q    <= '0;
						deadline_q <= '0;
						last_q     <= '0;
					end
				end
				ST_DIV: begin
					// zero steps leaves the record alone
					if (div_resp.done && (div_resp.quotient != '0)) begin
						if (div_resp.quotient >= TIME_BITS'(level_q)) begin
							streak_q   <= '0;
							level_q    <= '0;
							deadline_q <= '0;
							last_q     <= '0;
						end else begin
							level_q <= level_q - div_resp.quotient[LEVEL_W-1:0];
							// last plus steps times window equals now minus remainder
							last_q  <= now_q - TIME_BITS'(div_resp.remainder);
						end
					end
				end
				ST_FAIL: begin
					last_q <= now_q;
					if (streak_inc >= thresh_q) begin
						streak_q <= '0;
						if (level_q < MAX_LVL)
							level_q <= level_q + 1'b1;
					end else begin
						streak_q <= streak_inc;
					end
				end
				ST_SUM: begin
					deadline_q <= sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	// item latch, decay flag and lockout product
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_data.opcode;
			now_q <= in_data.now_ms;
			dec_q <= 1'b0;
		end else if ((state_q == ST_DIV) && div_resp.done && (div_resp.quotient != '0)) begin
			dec_q <= 1'b1;
		end
		if (state_q == ST_MUL)
			add_q <= ADD_W'(sec_q[sec_slot(level_q)] * ADD_W'(MS_PER_SEC));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((state_q == ST_DONE) && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_q.decayed          <= dec_q;
			out_q.level_out        <= level_q;
			out_q.streak_out       <= streak_q;
			out_q.lockout_until    <= deadline_q;
			out_q.last_failure_out <= last_q;
		end
	end

`ifndef ASSERT_OFF
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= MAX_LVL)
		else $error("lockout level above maximum");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_resp.busy)
		else $error("divider started while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after accepting a beat");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_resp.busy || div_resp.done))
		else $error("waiting on an idle divider");
`endif

endmodule

`default_nettype wire
